// File: rtl/mfbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfbp_pkg - shared constants and types for the msb-first bit packer
// buffer geometry, request codes, stream layout and controller/datapath links
// ----------------------------------------------------------------------------
package mfbp_pkg;

  localparam int BUFFER_BYTES  = 4096;
  localparam int MAX_ITEM_BITS = 64;

  // storage is organised as 64-bit words, byte 0 of a word in its top bits
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = BUFFER_BYTES / 8;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int OFS_W      = $clog2(WORD_BITS);
  localparam int POS_W      = 16;
  localparam int CNT_W      = 7;

  localparam logic [POS_W:0] CAP_BITS = (POS_W + 1)'(BUFFER_BYTES * 8);

  // request codes
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_ALIGN_W = 3'd2;
  localparam logic [2:0] REQ_ALIGN_R = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  // stream widths
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic latch;
    logic rd_a;
    logic rd_b;
    logic wr_a;
    logic wr_b;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic wr_go;
    logic rd_go;
    logic spans;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/mfbp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfbp_dp - datapath of the msb-first bit packer
// request registers, positions, word store, shift/merge logic, result beat
// ----------------------------------------------------------------------------
module mfbp_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mfbp_pkg::dp_cmd_t             cmd,
  output mfbp_pkg::dp_stat_t                 st,
  input  wire logic [mfbp_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic [mfbp_pkg::IN_USER_W-1:0] s_tuser,
  output logic [mfbp_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import mfbp_pkg::*;

  localparam int PAD_W = OUT_DATA_W - (WORD_BITS + 1 + 2 * POS_W);

  logic [2:0]           req_kind;
  logic [WORD_BITS-1:0] wdata;
  logic [CNT_W-1:0]     cnt;
  logic                 right_al;
  logic [POS_W-1:0]     wcount;
  logic [POS_W-1:0]     roff;
  logic [WORD_BITS-1:0] a_word;
  logic [WORD_BITS-1:0] mem_q;
  logic [WORD_BITS-1:0] mem [WORD_COUNT];

  logic [2:0]             rem;
  logic [2:0]             part_idx;
  logic                   has_part;
  logic                   cnt_ok;
  logic [POS_W:0]         wsum;
  logic [POS_W:0]         rsum;
  logic [POS_W-1:0]       pos;
  logic [OFS_W-1:0]       ofs;
  logic [ADDR_W-1:0]      addr_a;
  logic [ADDR_W-1:0]      addr_b;
  logic [WORD_BITS-1:0]   top_mask;
  logic [WORD_BITS-1:0]   keep_mask;
  logic [WORD_BITS-1:0]   item_l;
  logic [2*WORD_BITS-1:0] place;
  logic [2*WORD_BITS-1:0] cat;
  logic [WORD_BITS-1:0]   rd_l;
  logic [WORD_BITS-1:0]   rd_out;
  logic [WORD_BITS-1:0]   new_a;
  logic [WORD_BITS-1:0]   new_b;
  logic [POS_W:0]         walign;
  logic [POS_W:0]         ralign;
  logic [POS_W-1:0]       wcount_next;
  logic [POS_W-1:0]       roff_next;
  logic                   ok;
  logic [3:0]             part_sh;

  assign rem      = cnt[2:0];
  assign part_idx = cnt[5:3];
  assign has_part = (rem != 3'd0);
  assign part_sh  = 4'd8 - {1'b0, rem};
  assign cnt_ok   = (cnt != '0) && (cnt <= CNT_W'(MAX_ITEM_BITS));
  assign wsum     = {1'b0, wcount} + (POS_W + 1)'(cnt);
  assign rsum     = {1'b0, roff} + (POS_W + 1)'(cnt);

  assign st.wr_go = (req_kind == REQ_WRITE) && cnt_ok && (wsum <= CAP_BITS);
  assign st.rd_go = (req_kind == REQ_READ) && cnt_ok && (rsum <= {1'b0, wcount});
  assign st.spans = ((OFS_W + 2)'(ofs) + (OFS_W + 2)'(cnt)) > (OFS_W + 2)'(WORD_BITS);

  assign pos    = (req_kind == REQ_READ) ? roff : wcount;
  assign ofs    = pos[OFS_W-1:0];
  assign addr_a = pos[OFS_W +: ADDR_W];
  assign addr_b = addr_a + 1'b1;

  assign top_mask  = ~({WORD_BITS{1'b1}} >> cnt);
  assign keep_mask = ~({WORD_BITS{1'b1}} >> ofs);

  // item bits lined up msb first, item bit i at bit 63-i
  always_comb begin
    logic [7:0] lane;
    item_l = '0;
    for (int b = 0; b < WORD_BITS / 8; b++) begin
      lane = wdata[8*b +: 8];
      if (right_al && has_part && (part_idx == 3'(b))) begin
        lane = lane << part_sh;
      end
      item_l[WORD_BITS-1-8*b -: 8] = lane;
    end
    item_l = item_l & top_mask;
  end

  // bits before the write position are kept, bits past the end are zero
  assign place = {item_l, {WORD_BITS{1'b0}}} >> ofs;
  assign new_a = (mem_q & keep_mask) | place[2*WORD_BITS-1:WORD_BITS];
  assign new_b = place[WORD_BITS-1:0];

  assign cat  = {a_word, mem_q} << ofs;
  assign rd_l = cat[2*WORD_BITS-1:WORD_BITS] & top_mask;

  always_comb begin
    logic [7:0] lane;
    rd_out = '0;
    for (int b = 0; b < WORD_BITS / 8; b++) begin
      lane = rd_l[WORD_BITS-1-8*b -: 8];
      if (right_al && has_part && (part_idx == 3'(b))) begin
        lane = lane >> part_sh;
      end
      rd_out[8*b +: 8] = lane;
    end
    if (!st.rd_go) begin
      rd_out = '0;
    end
  end

  assign walign = ({1'b0, wcount} + (POS_W + 1)'(7)) & ~(POS_W + 1)'(7);
  assign ralign = ({1'b0, roff} + (POS_W + 1)'(7)) & ~(POS_W + 1)'(7);

  always_comb begin
    wcount_next = wcount;
    roff_next   = roff;
    ok          = 1'b0;
    unique case (req_kind)
      REQ_WRITE: begin
        ok = st.wr_go || (cnt == '0);
        if (st.wr_go) begin
          wcount_next = wsum[POS_W-1:0];
        end
      end
      REQ_READ: begin
        ok = st.rd_go;
        if (st.rd_go) begin
          roff_next = rsum[POS_W-1:0];
        end
      end
      REQ_ALIGN_W: begin
        ok = 1'b1;
        wcount_next = (walign > CAP_BITS) ? CAP_BITS[POS_W-1:0] : walign[POS_W-1:0];
      end
      REQ_ALIGN_R: begin
        ok = 1'b1;
        roff_next = ralign[POS_W-1:0];
      end
      REQ_CLEAR: begin
        ok = 1'b1;
        wcount_next = '0;
        roff_next   = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // positions
  always_ff @(posedge clk) begin
    if (rst) begin
      wcount <= '0;
      roff   <= '0;
    end else if (cmd.finish) begin
      wcount <= wcount_next;
      roff   <= roff_next;
    end
  end

  // request registers and result beat
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_kind <= s_tuser[2:0];
      right_al <= s_tuser[3];
      wdata    <= s_tdata[WORD_BITS-1:0];
      cnt      <= s_tdata[WORD_BITS +: CNT_W];
    end
    if (cmd.rd_b) begin
      a_word <= mem_q;
    end
    if (cmd.finish) begin
      m_tdata <= {{PAD_W{1'b0}}, roff_next, wcount_next, ok, rd_out};
    end
  end

  // word store, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_a || cmd.rd_b) begin
      mem_q <= mem[cmd.rd_b ? addr_b : addr_a];
    end
    if (cmd.wr_a || cmd.wr_b) begin
      mem[cmd.wr_b ? addr_b : addr_a] <= cmd.wr_b ? new_b : new_a;
    end
  end

  a_wcount_cap: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wcount} <= CAP_BITS)
    else $error("write count beyond buffer capacity");

  a_store_write_legal: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_a || cmd.wr_b) |-> st.wr_go)
    else $error("store written for a write request that failed its checks");

endmodule
`default_nettype wire

// File: rtl/mfbp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfbp_ctrl - request sequencer of the msb-first bit packer
// steps each request through decode, store access and result hand-off
// ----------------------------------------------------------------------------
module mfbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire mfbp_pkg::dp_stat_t st,
  output mfbp_pkg::dp_cmd_t      cmd
);
  import mfbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WR_A,
    S_WR_B,
    S_RD_B,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.latch  = (state == S_IDLE) && s_tvalid;
    cmd.rd_a   = (state == S_DECIDE) && (st.wr_go || st.rd_go);
    cmd.rd_b   = (state == S_RD_B);
    cmd.wr_a   = (state == S_WR_A);
    cmd.wr_b   = (state == S_WR_B);
    cmd.finish = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (st.wr_go) begin
            state <= S_WR_A;
          end else if (st.rd_go) begin
            state <= S_RD_B;
          end else begin
            state <= S_FIN;
          end
        end
        S_WR_A: begin
          state <= st.spans ? S_WR_B : S_FIN;
        end
        S_WR_B: begin
          state <= S_FIN;
        end
        S_RD_B: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result loaded over a beat not yet taken");

  a_wr_b_after_a: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_b |-> $past(cmd.wr_a))
    else $error("second word written without the first");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !(cmd.wr_a || cmd.wr_b || cmd.rd_a || cmd.rd_b))
    else $error("request accepted while store access in flight");

endmodule
`default_nettype wire

// File: rtl/msb_first_bit_packer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_packer_top - msb-first bit packer / unpacker
// appends and reads 1 to 64 bit items in a byte buffer, msb first
// ----------------------------------------------------------------------------
//
//  channel   dir  fields (lowest bit up)
//  --------  ---  ---------------------------------------------------------
//  s_*       in   tdata: write_data[63:0], bit_count[70:64], zero pad
//                 tuser: req_type[2:0], right_aligned[3]
//  m_*       out  tdata: read_data[63:0], ok[64], bits_written[80:65],
//                 read_position[96:81], zero pad
//
//  one request at a time, from accept to result beat:
//    decide, then finish; in between a read fetches the second word, a
//    write stores word one and, if the bits cross a 64-bit word, word two;
//  the 64-bit word store has one read and one write port: a write needs a
//  read-modify-write of the first word, a read fetches two words in turn
//  the result sits in an output register, so a new request is taken while
//  the previous beat is still waiting on m_tready
//  rst is synchronous; it clears both positions and the handshake state;
//  the word store has no reset and no clearing pass
//
module msb_first_bit_packer_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // requests
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // write_data[63:0], bit_count[70:64]
  input  wire logic [mfbp_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type[2:0], right_aligned[3]
  input  wire logic [mfbp_pkg::IN_USER_W-1:0]  s_tuser,
  // results
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // read_data[63:0], ok[64], bits_written[80:65], read_position[96:81]
  output logic [mfbp_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import mfbp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  // sequencer: decode, store access steps, result hand-off
  mfbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // positions, word store and the bit shifting around it
  mfbp_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .st      (st),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the msb-first bit packer
// drives write, read, align and clear requests into the request stream and
// checks every result beat against a bit-level shadow of the byte buffer
// ----------------------------------------------------------------------------
module testbench;

  import mfbp_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_PCT     = 30;
  localparam int ITEM_TARGET  = 1350;
  localparam int FIRST_BATCH  = 450;
  // idle-free stretch, counted in beats on each side
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 800;
  // long receiver hold-off, started once at this result beat
  localparam int HOLD_AT      = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 40;
  localparam int CAPACITY     = BUFFER_BYTES * 8;

  // request codes the block does not know
  localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] REQ_LAST_UNUSED  = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] bits;
    logic [6:0]  count;
    logic        right;
  } bit_req_t;

  typedef struct {
    logic [63:0] rdata;
    logic        ok;
    logic [15:0] wr_bits;
    logic [15:0] rd_pos;
  } bit_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // write_data[63:0], bit_count[70:64], zero pad
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  // req_type[2:0], right_aligned[3]
  logic [IN_USER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // read_data[63:0], ok[64], bits_written[80:65], read_position[96:81]
  logic [OUT_DATA_W-1:0] m_tdata;

  // stimulus and expectations
  bit_req_t    pending_reqs[$];
  bit_result_t expected_results[$];
  bit_req_t    offered;

  // shadow of the buffer and both positions
  bit [7:0]    shadow_bytes [BUFFER_BYTES];
  int unsigned shadow_wr = 0;
  int unsigned shadow_rd = 0;

  int unsigned queued_count    = 0;
  int unsigned accepted_count  = 0;
  int unsigned results_seen    = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned hold_left       = 0;
  int unsigned writes_done     = 0;
  int unsigned reads_done      = 0;
  int unsigned refused_count   = 0;
  int unsigned peak_fill       = 0;

  msb_first_bit_packer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow of the packer
  // ---------------------------------------------------------------------------

  // position in the 64-bit data word of stream bit i of an n-bit item;
  // a partial last byte sits in the low bits when right-justified
  function automatic int unsigned lane_index(int unsigned i, int unsigned n, bit right);
    int unsigned rem;
    rem = n & 7;
    if (rem != 0 && (i >> 3) == (n >> 3) && right)
      return (i >> 3) * 8 + (rem - 1) - (i & 7);
    return (i >> 3) * 8 + 7 - (i & 7);
  endfunction

  task automatic pack_predict(input bit_req_t r);
    bit_result_t res;
    int unsigned n;
    int unsigned pos;
    res.rdata = '0;
    res.ok    = 1'b0;
    n         = r.count;
    case (r.kind)
      REQ_WRITE: begin
        if (n == 0) begin
          res.ok = 1'b1;
        end else if (n <= MAX_ITEM_BITS && shadow_wr + n <= CAPACITY) begin
          for (int unsigned i = 0; i < n; i++) begin
            pos = shadow_wr + i;
            // first bit of a byte starts it afresh, so padding reads as zero
            if ((pos & 7) == 0) shadow_bytes[pos >> 3] = '0;
            shadow_bytes[pos >> 3][7 - (pos & 7)] = r.bits[lane_index(i, n, r.right)];
          end
          shadow_wr += n;
          res.ok = 1'b1;
          writes_done++;
        end
      end
      REQ_READ: begin
        if (n != 0 && n <= MAX_ITEM_BITS && shadow_rd + n <= shadow_wr) begin
          for (int unsigned i = 0; i < n; i++) begin
            pos = shadow_rd + i;
            res.rdata[lane_index(i, n, r.right)] = shadow_bytes[pos >> 3][7 - (pos & 7)];
          end
          shadow_rd += n;
          res.ok = 1'b1;
          reads_done++;
        end
      end
      REQ_ALIGN_W: begin
        shadow_wr = (shadow_wr + 7) & ~32'd7;
        if (shadow_wr > CAPACITY) shadow_wr = CAPACITY;
        res.ok = 1'b1;
      end
      REQ_ALIGN_R: begin
        shadow_rd = (shadow_rd + 7) & ~32'd7;
        res.ok = 1'b1;
      end
      REQ_CLEAR: begin
        shadow_wr = 0;
        shadow_rd = 0;
        res.ok = 1'b1;
      end
      default: res.ok = 1'b0;
    endcase
    if (!res.ok) refused_count++;
    if (shadow_wr > peak_fill) peak_fill = shadow_wr;
    res.wr_bits = shadow_wr[15:0];
    res.rd_pos  = shadow_rd[15:0];
    expected_results.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // request side: one beat held until taken, random gaps between beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pack_predict(offered);
        accepted_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 &&
            ((accepted_count >= QUIET_FROM && accepted_count < QUIET_TO) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, offered.count, offered.bits};
          s_tuser  <= {offered.right, offered.kind};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: compare each beat with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  task automatic check_result_beat();
    bit_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: result beat with nothing pending, expected none, actual %h",
                 $time, m_tdata);
    end else begin
      want = expected_results.pop_front();
      check_field("read_data",     want.rdata,   m_tdata[63:0]);
      check_field("ok",            want.ok,      m_tdata[64]);
      check_field("bits_written",  want.wr_bits, m_tdata[80:65]);
      check_field("read_position", want.rd_pos,  m_tdata[96:81]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result_beat();
        results_seen++;
        // one long hold-off so the block backs up into the request side
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= (results_seen >= QUIET_FROM && results_seen < QUIET_TO) ||
                    ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [2:0] kind, input logic [63:0] bits,
                          input int unsigned count, input logic right);
    bit_req_t r;
    r.kind  = kind;
    r.bits  = bits;
    r.count = count[6:0];
    r.right = right;
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  // refused or ignored requests, and counts outside the item range
  task automatic push_noise();
    case ($urandom_range(0, 4))
      0: push_req($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED), {$urandom, $urandom},
                  $urandom_range(0, 127), $urandom_range(0, 1));
      1: push_req(REQ_WRITE, {$urandom, $urandom}, $urandom_range(65, 127),
                  $urandom_range(0, 1));
      2: push_req(REQ_READ, {$urandom, $urandom}, $urandom_range(65, 127),
                  $urandom_range(0, 1));
      3: push_req(REQ_READ, {$urandom, $urandom}, 0, $urandom_range(0, 1));
      default: push_req(REQ_WRITE, {$urandom, $urandom}, 0, $urandom_range(0, 1));
    endcase
  endtask

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 9))
      6, 7:    return MAX_ITEM_BITS;
      8, 9:    return $urandom_range(1, 8);
      default: return $urandom_range(1, MAX_ITEM_BITS);
    endcase
  endfunction

  // a run of writes read back with the same sizes, salted with noise
  task automatic queue_frame();
    int unsigned sizes[$];
    int unsigned n;
    if ($urandom_range(0, 99) < 80) begin
      push_req(REQ_CLEAR, {$urandom, $urandom}, $urandom_range(0, 127), $urandom_range(0, 1));
    end else begin
      push_req(REQ_ALIGN_W, {$urandom, $urandom}, $urandom_range(0, 127), 1'b0);
      push_req(REQ_ALIGN_R, {$urandom, $urandom}, $urandom_range(0, 127), 1'b1);
    end
    repeat ($urandom_range(2, 8)) begin
      n = pick_size();
      sizes.push_back(n);
      push_req(REQ_WRITE, {$urandom, $urandom}, n, $urandom_range(0, 1));
      if ($urandom_range(0, 99) < 8) push_noise();
      if ($urandom_range(0, 99) < 8) push_req(REQ_ALIGN_W, {$urandom, $urandom}, 0, 1'b0);
    end
    foreach (sizes[k]) begin
      push_req(REQ_READ, {$urandom, $urandom}, sizes[k], $urandom_range(0, 1));
      if ($urandom_range(0, 99) < 8) push_noise();
      if ($urandom_range(0, 99) < 5) push_req(REQ_ALIGN_R, {$urandom, $urandom}, 0, 1'b0);
    end
    // usually runs past the written bits
    if ($urandom_range(0, 99) < 30)
      push_req(REQ_READ, {$urandom, $urandom}, MAX_ITEM_BITS, $urandom_range(0, 1));
  endtask

  // sender pause: hold back until every outstanding result has come
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, every request and the corner cases
    push_req(REQ_WRITE, '1, 64, 1'b0);                  // full-width item
    push_req(REQ_WRITE, 64'h1, 1, 1'b1);                // single bit
    push_req(REQ_WRITE, 64'h55, 7, 1'b1);               // partial byte, low bits
    push_req(REQ_WRITE, 64'hA5F0, 13, 1'b0);            // partial byte, top bits
    push_req(REQ_WRITE, '1, 0, 1'b0);                   // zero count, no change
    push_req(REQ_WRITE, '1, 65, 1'b1);                  // count above item size
    push_req(REQ_WRITE, '1, 127, 1'b0);
    push_req(REQ_READ, '0, 0, 1'b0);                    // zero-count read refused
    push_req(REQ_READ, '0, 64, 1'b0);
    push_req(REQ_READ, '0, 1, 1'b1);
    push_req(REQ_READ, '0, 7, 1'b1);
    push_req(REQ_READ, '0, 13, 1'b0);
    push_req(REQ_READ, '0, 1, 1'b0);                    // underrun
    push_req(REQ_READ, '0, 65, 1'b1);
    push_req(REQ_ALIGN_W, '0, 0, 1'b0);                 // pads with zeros
    push_req(REQ_WRITE, 64'h5, 3, 1'b1);
    push_req(REQ_ALIGN_R, '0, 0, 1'b0);
    push_req(REQ_READ, '0, 3, 1'b1);
    push_req(REQ_ALIGN_R, '0, 0, 1'b0);                 // moves past written bits
    push_req(REQ_READ, '0, 1, 1'b0);
    push_req(REQ_WRITE, '1, 5, 1'b0);
    push_req(REQ_FIRST_UNUSED, '1, 127, 1'b1);          // unknown requests ignored
    push_req(REQ_LAST_UNUSED, '0, 64, 1'b0);
    push_req(REQ_CLEAR, '0, 0, 1'b0);
    push_req(REQ_READ, '0, 1, 1'b0);
    push_req(REQ_ALIGN_W, '0, 0, 1'b1);
    push_req(REQ_ALIGN_R, '0, 0, 1'b1);
    wait_drained();

    while (queued_count < FIRST_BATCH) queue_frame();
    wait_drained();

    // fill the buffer to the last bit, then try to go past it
    push_req(REQ_CLEAR, '0, 0, 1'b0);
    repeat (CAPACITY / MAX_ITEM_BITS - 1)
      push_req(REQ_WRITE, {$urandom, $urandom}, MAX_ITEM_BITS, $urandom_range(0, 1));
    push_req(REQ_WRITE, {$urandom, $urandom}, 60, 1'b1);
    push_req(REQ_WRITE, {$urandom, $urandom}, 5, 1'b0);  // overflow
    push_req(REQ_WRITE, {$urandom, $urandom}, 4, 1'b1);  // exactly full
    push_req(REQ_WRITE, {$urandom, $urandom}, 1, 1'b0);  // overflow
    push_req(REQ_WRITE, {$urandom, $urandom}, 0, 1'b0);
    push_req(REQ_ALIGN_W, '0, 0, 1'b0);                  // stays at capacity
    repeat (6) push_req(REQ_READ, '0, pick_size(), $urandom_range(0, 1));
    push_req(REQ_ALIGN_R, '0, 0, 1'b0);
    push_req(REQ_READ, '0, MAX_ITEM_BITS, 1'b1);
    wait_drained();

    while (queued_count < ITEM_TARGET) queue_frame();
    wait_drained();

    // let any stray beat show itself
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests checked: %0d writes and %0d reads done, %0d refused",
             results_seen, writes_done, reads_done, refused_count);
    $display("buffer filled to %0d of %0d bits, long hold-off of %0d cycles on results",
             peak_fill, CAPACITY, HOLD_CYCLES);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mfbp_pkg.sv
rtl/mfbp_dp.sv
rtl/mfbp_ctrl.sv
rtl/msb_first_bit_packer_top.sv
tb/testbench.sv
